@@ rtl/core/ort_pkg.sv @@
// Package for the ordered record table: sizes, command and status codes,
// controller state and the structs passed between modules. No dependencies.
`default_nettype none

package ort_pkg;

  localparam int DEPTH     = 256;
  localparam int REC_WIDTH = 32;

  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the ports
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 9;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 9;
  localparam int CNT_OUT_W = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_APPEND = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_SHIFT,
    S_INS_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [REC_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_e              status;
    logic [VAL_W-1:0]     read_value;
    logic [CNT_OUT_W-1:0] rec_count;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/ort_if.sv @@
// Valid/ready channels of the ordered record table: command items in,
// result items out. Depends on ort_pkg for field widths.
`default_nettype none

interface ort_req_if;
  import ort_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] record_index;
  logic [VAL_W-1:0] record_value;

  modport source (output valid, cmd, record_index, record_value, input ready);
  modport sink   (input valid, cmd, record_index, record_value, output ready);
endinterface

interface ort_rsp_if;
  import ort_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [VAL_W-1:0]     read_value;
  logic [CNT_OUT_W-1:0] rec_count;

  modport source (output valid, status, read_value, rec_count, input ready);
  modport sink   (input valid, status, read_value, rec_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ort_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No dependencies.
`default_nettype none

module ort_ram #(
  parameter int DATA_W    = 32,
  parameter int NUM_WORDS = 256,
  localparam int AW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/ort_ctrl.sv @@
// Command sequencer of the ordered record table: decodes one item, runs the
// read/shift/write steps against the record RAM and keeps the record count.
// Depends on ort_pkg and ort_if.
`default_nettype none

module ort_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ort_req_if.sink                    req_i,
  input  wire logic [ort_pkg::CNT_W-1:0]     lim_i,
  input  wire logic [ort_pkg::REC_WIDTH-1:0] rdata_i,
  output ort_pkg::ram_req_t          ram_req_o,
  input  wire logic                  slot_free_i,
  output logic                       res_valid_o,
  output ort_pkg::res_t              res_o
);
  import ort_pkg::*;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [REC_WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0]     count_q, count_d;
  status_e              status_q, status_d;
  logic [VAL_W-1:0]     rdata_q, rdata_d;
  logic [ADDR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0]    last_q, last_d;
  logic [ADDR_W-1:0]    pend_addr_q, pend_addr_d;
  logic                 more_q, more_d;
  logic                 pend_q, pend_d;

  logic in_range, is_full, is_ins;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      more_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      more_q  <= more_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    val_q       <= val_d;
    status_q    <= status_d;
    rdata_q     <= rdata_d;
    rd_ptr_q    <= rd_ptr_d;
    last_q      <= last_d;
    pend_addr_q <= pend_addr_d;
  end

  assign in_range = (idx_q != '0) && (32'(idx_q) <= 32'(count_q));
  assign is_full  = (count_q >= lim_i);
  assign is_ins   = (cmd_q == CMD_INSERT);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    val_d       = val_q;
    count_d     = count_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    rd_ptr_d    = rd_ptr_q;
    last_d      = last_q;
    pend_addr_d = pend_addr_q;
    more_d      = more_q;
    pend_d      = pend_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = pend_addr_q;
    ram_req_o.wdata = val_q;
    ram_req_o.raddr = rd_ptr_q;
    req_i.ready     = (state_q == S_IDLE);
    res_valid_o     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d    = cmd_e'(req_i.cmd);
          idx_d    = req_i.record_index;
          val_d    = REC_WIDTH'(req_i.record_value);
          status_d = ST_OK;
          rdata_d  = '0;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_RESP;
        unique case (cmd_q)
          CMD_READ: begin
            if (in_range) begin
              ram_req_o.raddr = ADDR_W'(idx_q - 1'b1);
              state_d         = S_RD_WAIT;
            end else begin
              status_d = ST_RANGE;
            end
          end
          CMD_UPDATE: begin
            if (in_range) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = ADDR_W'(idx_q - 1'b1);
            end else begin
              status_d = ST_RANGE;
            end
          end
          CMD_INSERT: begin
            if (is_full) begin
              status_d = ST_FULL;
            end else if (count_q == '0) begin
              if (idx_q != IDX_W'(1)) begin
                status_d = ST_RANGE;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = '0;
                count_d         = CNT_W'(1);
              end
            end else if (!in_range) begin
              status_d = ST_RANGE;
            end else begin
              // move records n-1 down to idx-1 up by one, top first
              rd_ptr_d = ADDR_W'(count_q - 1'b1);
              last_d   = ADDR_W'(idx_q - 1'b1);
              more_d   = 1'b1;
              pend_d   = 1'b0;
              state_d  = S_SHIFT;
            end
          end
          CMD_DELETE: begin
            if (!in_range) begin
              status_d = ST_RANGE;
            end else if (32'(idx_q) == 32'(count_q)) begin
              count_d = count_q - 1'b1;   // last record, nothing to move
            end else begin
              // move records idx..n-1 down by one, bottom first
              rd_ptr_d = ADDR_W'(idx_q);
              last_d   = ADDR_W'(count_q - 1'b1);
              more_d   = 1'b1;
              pend_d   = 1'b0;
              state_d  = S_SHIFT;
            end
          end
          CMD_APPEND: begin
            if (is_full) begin
              status_d = ST_FULL;
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = ADDR_W'(count_q);
              count_d         = count_q + 1'b1;
            end
          end
          CMD_CLEAR: begin
            count_d = '0;
          end
          default: begin
            status_d = ST_RANGE;
          end
        endcase
      end

      S_RD_WAIT: begin
        rdata_d = VAL_W'(rdata_i);
        state_d = S_RESP;
      end

      S_SHIFT: begin
        // write back the record read last cycle, one slot over
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = is_ins ? pend_addr_q + 1'b1 : pend_addr_q - 1'b1;
          ram_req_o.wdata = rdata_i;
        end
        if (more_q) begin
          ram_req_o.raddr = rd_ptr_q;
          pend_d          = 1'b1;
          pend_addr_d     = rd_ptr_q;
          if (rd_ptr_q == last_q) begin
            more_d = 1'b0;
          end else begin
            rd_ptr_d = is_ins ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
          if (is_ins) begin
            state_d = S_INS_WR;
          end else begin
            count_d = count_q - 1'b1;
            state_d = S_RESP;
          end
        end
      end

      S_INS_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = last_q;
        count_d         = count_q + 1'b1;
        state_d         = S_RESP;
      end

      S_RESP: begin
        res_valid_o = slot_free_i;
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status     = status_q;
  assign res_o.read_value = rdata_q;
  assign res_o.rec_count  = CNT_OUT_W'(count_q);

endmodule

`default_nettype wire

@@ rtl/core/ordered_record_table.sv @@
// Ordered record table: an insert or a delete that moves k records does one
// RAM read and one write per move. Items are taken one at a time; the next
// item is accepted in the cycle after the previous result leaves the
// sequencer, even while that result waits in the output register.
// Reset: count 0, cap 256.
`default_nettype none

module ordered_record_table (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [ort_pkg::CAP_W-1:0] cfg_wdata_i,
  ort_req_if.sink                     req_i,
  ort_rsp_if.source                   rsp_o
);
  import ort_pkg::*;

  // capacity register and effective limit min(capacity, DEPTH)
  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign lim = (32'(cap_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_q);

  // sequencer and record RAM
  ram_req_t             ram_req;
  logic [REC_WIDTH-1:0] ram_rdata;
  logic                 res_valid;
  res_t                 res;
  logic                 slot_free;

  ort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .lim_i       (lim),
    .rdata_i     (ram_rdata),
    .ram_req_o   (ram_req),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ort_ram #(
    .DATA_W    (REC_WIDTH),
    .NUM_WORDS (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // output register: holds one finished result while the sequencer
  // moves on to the next item
  logic out_valid_q, out_valid_d;
  res_t out_q;

  assign slot_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.read_value = out_q.read_value;
  assign rsp_o.rec_count  = out_q.rec_count;

endmodule

`default_nettype wire

@@ rtl/core/ordered_record_table_chk.sv @@
// Port-level checker for the ordered record table, bound to the top level.
// Depends on ort_pkg; watches only the top-level channels.
`default_nettype none

module ordered_record_table_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [ort_pkg::STAT_W-1:0]    status_i,
  input wire logic [ort_pkg::VAL_W-1:0]     read_value_i,
  input wire logic [ort_pkg::CNT_OUT_W-1:0] rec_count_i
);
  import ort_pkg::*;

  // items accepted whose result has not been taken yet
  logic [1:0] outst_q, outst_d;
  logic       acc, del;

  assign acc = in_valid_i && in_ready_i;
  assign del = out_valid_i && out_ready_i;

  always_comb begin
    outst_d = outst_q + 2'(acc) - 2'(del);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(read_value_i) && $stable(rec_count_i))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> outst_q != 2'd0)
    else $error("result without a pending item");

  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= 2'd2)
    else $error("more than two items in flight");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> read_value_i == '0
      && 32'(rec_count_i) <= DEPTH)
    else $error("failed command returned data or bad count");

endmodule

bind ordered_record_table ordered_record_table_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .read_value_i (rsp_o.read_value),
  .rec_count_i  (rsp_o.rec_count)
);

`default_nettype wire

@@ dv/tb_ordered_record_table.sv @@
// Testbench for ordered_record_table: drives command items, predicts every
// result from a shadow copy of the table and checks results in order.
// Depends on ort_pkg, ort_req_if / ort_rsp_if and the ordered_record_table RTL.
`timescale 1ns / 100ps

module tb_ordered_record_table;
  import ort_pkg::*;

  // Command codes the block does not define; both must answer out of range.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Slowest item is a full-depth shift behind a long output hold-off plus
  // random gaps; several times that is plenty.
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 32;
  localparam int ROUNDS       = 10;
  localparam int ROUND_ITEMS  = 55;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  ort_req_if req_bus ();
  ort_rsp_if rsp_bus ();

  ordered_record_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // Shadow of the table: contents, record count and configured capacity.
  logic [REC_WIDTH-1:0] shadow_rec [DEPTH];
  int unsigned          shadow_count;
  int unsigned          shadow_cap;

  // Results still owed by the block, oldest first.
  res_t pending_results [$];
  res_t oldest_result;

  int  mismatch_total;
  int  quiet_cycles;
  bit  steady_flow;    // no random idling on either side while set
  bit  hold_request;   // asks the ready driver for one long hold-off
  int  hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted command to the shadow table and returns
  // the result the block must give for it.
  // ---------------------------------------------------------------------------
  function automatic res_t apply_command(logic [CMD_W-1:0] op, logic [IDX_W-1:0] pos,
                                         logic [VAL_W-1:0] data);
    res_t        r;
    int unsigned n;
    int unsigned lim;
    int          p;
    int          k;
    bit          in_range;
    n        = shadow_count;
    lim      = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    p        = pos;
    in_range = (p >= 1) && (p <= n);
    r.status       = ST_OK;
    r.read_value   = '0;
    case (op)
      CMD_READ: begin
        if (in_range) r.read_value = shadow_rec[p-1];
        else r.status = ST_RANGE;
      end
      CMD_UPDATE: begin
        if (in_range) shadow_rec[p-1] = data[REC_WIDTH-1:0];
        else r.status = ST_RANGE;
      end
      CMD_INSERT: begin
        // full wins over range; an empty table takes position 1 only
        if (n >= lim) begin
          r.status = ST_FULL;
        end else if (n == 0) begin
          if (p != 1) begin
            r.status = ST_RANGE;
          end else begin
            shadow_rec[0] = data[REC_WIDTH-1:0];
            n = 1;
          end
        end else if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          for (k = n; k >= p; k--) shadow_rec[k] = shadow_rec[k-1];
          shadow_rec[p-1] = data[REC_WIDTH-1:0];
          n++;
        end
      end
      CMD_DELETE: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          for (k = p; k < n; k++) shadow_rec[k-1] = shadow_rec[k];
          n--;
        end
      end
      CMD_APPEND: begin
        if (n >= lim) begin
          r.status = ST_FULL;
        end else begin
          shadow_rec[n] = data[REC_WIDTH-1:0];
          n++;
        end
      end
      CMD_CLEAR: n = 0;
      default:   r.status = ST_RANGE;
    endcase
    shadow_count = n;
    r.rec_count  = n[CNT_OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one item per call. Starts at a falling edge, idles at random,
  // then holds the item until the block takes it. Prediction happens here,
  // at the accepting edge, so the next pick already sees the new count.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(logic [CMD_W-1:0] op, logic [IDX_W-1:0] pos,
                          logic [VAL_W-1:0] data);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.cmd          <= op;
    req_bus.record_index <= pos;
    req_bus.record_value <= data;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_results.push_back(apply_command(op, pos, data));
  endtask

  // Mostly well-formed commands with positions inside the table; the rest
  // is noise over the whole field ranges, spare codes included.
  task automatic send_random_cmd();
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] pos;
    int               roll;
    roll = $urandom_range(99);
    pos  = (shadow_count == 0) ? 9'd1 : IDX_W'($urandom_range(shadow_count, 1));
    if ($urandom_range(99) < 12) begin
      op  = CMD_W'($urandom_range(7));
      pos = IDX_W'($urandom_range(511));
    end else if (roll < 25) op = CMD_READ;
    else if (roll < 40) op = CMD_UPDATE;
    else if (roll < 60) op = CMD_INSERT;
    else if (roll < 74) op = CMD_DELETE;
    else if (roll < 94) op = CMD_APPEND;
    else op = CMD_CLEAR;
    send_cmd(op, pos, $urandom);
  endtask

  // Drops valid and waits until every result is back, so the block is idle.
  task automatic wait_drained();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(int unsigned cap);
    wait_drained();
    @(negedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= CAP_W'(cap);
    shadow_cap  = cap & 9'h1FF;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (steady_flow) begin
      rsp_bus.ready <= 1'b1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d read_value 'h%08h rec_count %0d",
               rsp_bus.status, rsp_bus.read_value, rsp_bus.rec_count);
        mismatch_total++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_bus.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, rsp_bus.status);
          mismatch_total++;
        end
        if (rsp_bus.read_value !== oldest_result.read_value) begin
          $error("read_value: expected 'h%08h, got 'h%08h",
                 oldest_result.read_value, rsp_bus.read_value);
          mismatch_total++;
        end
        if (rsp_bus.rec_count !== oldest_result.rec_count) begin
          $error("rec_count: expected %0d, got %0d",
                 oldest_result.rec_count, rsp_bus.rec_count);
          mismatch_total++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side means a hang.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ordered_record_table: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: nothing is in range, insert only at 1, spare codes rejected.
  task automatic test_empty_table();
    send_cmd(CMD_READ,     9'd1,   32'h0);
    send_cmd(CMD_DELETE,   9'd1,   32'h0);
    send_cmd(CMD_UPDATE,   9'd0,   32'hFFFF_FFFF);
    send_cmd(CMD_INSERT,   9'd2,   32'h1);
    send_cmd(CMD_SPARE_LO, 9'd511, 32'hFFFF_FFFF);
    send_cmd(CMD_SPARE_HI, 9'd1,   32'h0);
    send_cmd(CMD_CLEAR,    9'd511, 32'h0);
  endtask

  // Insert on empty acts as append; then shifts at both ends, edits, reads.
  task automatic test_edit_commands();
    send_cmd(CMD_INSERT, 9'd1,   32'hFFFF_FFFF);
    send_cmd(CMD_APPEND, 9'd511, 32'h0000_0000);
    send_cmd(CMD_INSERT, 9'd1,   32'hA5A5_A5A5);
    send_cmd(CMD_INSERT, 9'd3,   32'h1234_5678);
    send_cmd(CMD_UPDATE, 9'd4,   32'h5A5A_5A5A);
    send_cmd(CMD_READ,   9'd1,   32'h0);
    send_cmd(CMD_READ,   9'd4,   32'h0);
    send_cmd(CMD_DELETE, 9'd4,   32'h0);
    send_cmd(CMD_DELETE, 9'd1,   32'h0);
    send_cmd(CMD_READ,   9'd2,   32'h0);
  endtask

  // Positions 0, count + 1 and the top of the index field.
  task automatic test_range_checks();
    send_cmd(CMD_READ,   9'd0,   32'h0);
    send_cmd(CMD_READ,   9'd3,   32'h0);
    send_cmd(CMD_INSERT, 9'd3,   32'h7);
    send_cmd(CMD_DELETE, 9'd511, 32'h0);
    send_cmd(CMD_UPDATE, 9'd256, 32'h9);
    send_cmd(CMD_CLEAR,  9'd0,   32'h0);
    send_cmd(CMD_READ,   9'd1,   32'h0);
  endtask

  // Capacity zero, full before range, and capacity dropped below the count.
  task automatic test_capacity_limits();
    set_capacity(0);
    send_cmd(CMD_APPEND, 9'd0, 32'h1);
    send_cmd(CMD_INSERT, 9'd0, 32'h2);
    set_capacity(2);
    send_cmd(CMD_APPEND, 9'd0, 32'hDEAD_BEEF);
    send_cmd(CMD_APPEND, 9'd0, 32'h0BAD_F00D);
    send_cmd(CMD_APPEND, 9'd0, 32'h3);
    send_cmd(CMD_INSERT, 9'd1, 32'h4);
    set_capacity(1);
    send_cmd(CMD_READ,   9'd2, 32'h0);
    send_cmd(CMD_APPEND, 9'd0, 32'h5);
    send_cmd(CMD_DELETE, 9'd1, 32'h0);
    send_cmd(CMD_APPEND, 9'd0, 32'h6);
    send_cmd(CMD_DELETE, 9'd1, 32'h0);
    send_cmd(CMD_APPEND, 9'd0, 32'h7);
  endtask

  // Capacity above the store saturates at DEPTH; full-depth shifts once each.
  task automatic test_depth_saturation();
    int i;
    set_capacity(511);
    send_cmd(CMD_CLEAR, 9'd0, 32'h0);
    for (i = 0; i < DEPTH; i++) send_cmd(CMD_APPEND, IDX_W'($urandom_range(511)), $urandom);
    send_cmd(CMD_APPEND, 9'd0,   32'h1);
    send_cmd(CMD_INSERT, 9'd1,   32'h2);
    send_cmd(CMD_READ,   9'd256, 32'h0);
    send_cmd(CMD_DELETE, 9'd1,   32'h0);
    send_cmd(CMD_INSERT, 9'd1,   32'hC0FF_EE00);
    send_cmd(CMD_READ,   9'd256, 32'h0);
    send_cmd(CMD_DELETE, 9'd256, 32'h0);
    send_cmd(CMD_CLEAR,  9'd0,   32'h0);
  endtask

  // Result side stalls for a long stretch while items keep coming, so the
  // output register fills and the block has to stall its input.
  task automatic test_output_backpressure();
    int i;
    set_capacity(256);
    steady_flow  = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) send_random_cmd();
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // Rounds of random traffic, each under its own capacity; mostly small
  // capacities so the shifts stay short. One round runs with no idling.
  task automatic test_random_traffic();
    int round;
    int i;
    int unsigned cap;
    for (round = 0; round < ROUNDS; round++) begin
      if (round == 0) cap = 511;
      else if (round == 1) cap = 0;
      else if ($urandom_range(99) < 70) cap = $urandom_range(24, 1);
      else cap = $urandom_range(511, 25);
      set_capacity(cap);
      steady_flow = (round == 3);
      for (i = 0; i < ROUND_ITEMS; i++) send_random_cmd();
    end
    wait_drained();
    steady_flow = 1'b0;
  endtask

  initial begin
    req_bus.valid        = 1'b0;
    req_bus.cmd          = CMD_READ;
    req_bus.record_index = '0;
    req_bus.record_value = '0;
    rsp_bus.ready        = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    rst_ni               = 1'b0;
    shadow_count         = 0;
    shadow_cap           = CAP_RESET;
    mismatch_total       = 0;
    quiet_cycles         = 0;
    steady_flow          = 1'b0;
    hold_request         = 1'b0;
    hold_left            = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_edit_commands();
    test_range_checks();
    test_capacity_limits();
    test_depth_saturation();
    test_output_backpressure();
    test_random_traffic();

    // wait until all results are in, then watch for stray output
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("ordered_record_table: match");
    end else begin
      $display("ordered_record_table: mismatch");
    end
    $finish;
  end

endmodule
